### hdl/task_priority_table_assert.svh
// assertion macros for the task table rtl, used by task_priority_table
`ifndef TASK_PRIORITY_TABLE_ASSERT_SVH
`define TASK_PRIORITY_TABLE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define TPT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TPT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tpt_pkg.sv
package tpt_pkg;

  localparam int PRIO_W    = 31;
  localparam int USER_W    = 16;
  localparam int TID_W     = 10;
  localparam int CELL_BITS = 2;
  localparam int CELLS     = 1 << CELL_BITS;

  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [USER_W-1:0] user;
  } entry_t;

  typedef struct packed {
    logic                 wr_en;
    logic                 wr_all;
    logic [CELL_BITS-1:0] wr_cell;
    entry_t               wr_word;
  } cell_cmd_t;

  typedef struct packed {
    logic              active;
    logic              best_valid;
    logic [PRIO_W-1:0] best_prio;
    logic [USER_W-1:0] best_user;
  } scan_t;

endpackage

### hdl/task_priority_table.sv
// channel   signals                                      transfer
// request   req_type user_id task_id priority_req       start && !busy
// result    found out_user                               done, one cycle, no stall
//
// add and remove: done is registered in S_CMD; edit: in S_EDIT, or in S_CMD if out of range
// execute top: all ROWS rows pass the cell chain, then S_TAKE clears the winner; ROWS = ceil(TASK_SLOTS/CELLS);
// one row per cycle enters the cell chain, each cell adds two stages
// after reset a clearing pass writes every row, from row 0 to the last, with busy high
// busy stays high from the transfer until done; the receiver cannot stall
`include "task_priority_table_assert.svh"

module task_priority_table #(
  parameter int TASK_SLOTS = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  req_type,
  input  logic [tpt_pkg::USER_W-1:0]  user_id,
  input  logic [tpt_pkg::TID_W-1:0]   task_id,
  input  logic [tpt_pkg::PRIO_W-1:0]  priority_req,
  output logic                        done,
  output logic                        found,
  output logic [tpt_pkg::USER_W-1:0]  out_user
);
  import tpt_pkg::*;

  localparam int ROWS   = (TASK_SLOTS + CELLS - 1) / CELLS;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = ROW_W + CELL_BITS;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_EDIT   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_EXEC   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CMD,
    S_EDIT,
    S_SCAN,
    S_TAKE
  } state_t;

  state_t               state;
  req_t                 req_q;
  logic [USER_W-1:0]    user_q;
  logic [PRIO_W-1:0]    prio_q;
  logic [CELL_BITS-1:0] cell_q;
  logic [ROW_W-1:0]     row_q;
  logic                 in_range_q;
  logic [ROW_W-1:0]     clr_row;
  logic                 scan_on;
  logic [ROW_W-1:0]     scan_row;
  logic                 acc_v;
  logic [PRIO_W-1:0]    acc_prio;
  logic [USER_W-1:0]    acc_user;
  logic [SLOT_W-1:0]    acc_slot;
  logic                 acc_take;

  cell_cmd_t            cmd;
  logic [ROW_W-1:0]     wr_row;
  scan_t                chain      [CELLS+1];
  logic [ROW_W-1:0]     chain_row  [CELLS+1];
  logic [SLOT_W-1:0]    chain_slot [CELLS+1];
  entry_t               rd_words   [CELLS];

  assign chain[0].active     = scan_on;
  assign chain[0].best_valid = 1'b0;
  assign chain[0].best_prio  = '0;
  assign chain[0].best_user  = '0;
  assign chain_row[0]        = scan_row;
  assign chain_slot[0]       = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    tpt_cell #(
      .ROWS     (ROWS),
      .ROW_W    (ROW_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .wr_row        (wr_row),
      .rd_row        (row_q),
      .scan_in       (chain[k]),
      .scan_row_in   (chain_row[k]),
      .scan_slot_in  (chain_slot[k]),
      .scan_out      (chain[k+1]),
      .scan_row_out  (chain_row[k+1]),
      .scan_slot_out (chain_slot[k+1]),
      .rd_word       (rd_words[k])
    );
  end

  // rows arrive in increasing order, so a tie goes to the later row
  assign acc_take = chain[CELLS].active && chain[CELLS].best_valid &&
                    (!acc_v || (chain[CELLS].best_prio >= acc_prio));

  always_comb begin
    cmd     = '0;
    wr_row  = row_q;
    cmd.wr_cell = cell_q;
    unique case (state)
      S_CLEAR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_all = 1'b1;
        wr_row     = clr_row;
      end
      S_CMD: begin
        if (in_range_q && (req_q == REQ_ADD)) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_word = '{valid: 1'b1, prio: prio_q, user: user_q};
        end else if (in_range_q && (req_q == REQ_REMOVE)) begin
          cmd.wr_en = 1'b1;
        end
      end
      S_EDIT: begin
        if (rd_words[cell_q].valid) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_word = '{valid: 1'b1, prio: prio_q, user: rd_words[cell_q].user};
        end
      end
      S_TAKE: begin
        cmd.wr_en   = acc_v;
        cmd.wr_cell = acc_slot[CELL_BITS-1:0];
        wr_row      = acc_slot[SLOT_W-1:CELL_BITS];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    done     <= 1'b0;
    found    <= 1'b0;
    out_user <= '0;
    if (rst) begin
      state   <= S_CLEAR;
      clr_row <= '0;
      busy    <= 1'b1;
      scan_on <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_row == LAST_ROW) begin
            busy  <= 1'b0;
            state <= S_IDLE;
          end else begin
            clr_row <= clr_row + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            req_q      <= req_t'(req_type);
            user_q     <= user_id;
            prio_q     <= priority_req;
            cell_q     <= task_id[CELL_BITS-1:0];
            row_q      <= ROW_W'(task_id >> CELL_BITS);
            in_range_q <= (32'(task_id) < TASK_SLOTS);
            busy       <= 1'b1;
            state      <= S_CMD;
          end
        end
        S_CMD: begin
          unique case (req_q)
            REQ_ADD, REQ_REMOVE: begin
              done  <= 1'b1;
              busy  <= 1'b0;
              state <= S_IDLE;
            end
            REQ_EDIT: begin
              if (in_range_q) begin
                state <= S_EDIT;
              end else begin
                done  <= 1'b1;
                busy  <= 1'b0;
                state <= S_IDLE;
              end
            end
            REQ_EXEC: begin
              scan_on  <= 1'b1;
              scan_row <= '0;
              acc_v    <= 1'b0;
              state    <= S_SCAN;
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_EDIT: begin
          done  <= 1'b1;
          found <= rd_words[cell_q].valid;
          busy  <= 1'b0;
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_on) begin
            if (scan_row == LAST_ROW) begin
              scan_on <= 1'b0;
            end else begin
              scan_row <= scan_row + 1'b1;
            end
          end
          if (acc_take) begin
            acc_v    <= 1'b1;
            acc_prio <= chain[CELLS].best_prio;
            acc_user <= chain[CELLS].best_user;
            acc_slot <= chain_slot[CELLS];
          end
          if (chain[CELLS].active && (chain_row[CELLS] == LAST_ROW)) begin
            state <= S_TAKE;
          end
        end
        S_TAKE: begin
          done     <= 1'b1;
          found    <= acc_v;
          out_user <= acc_v ? acc_user : '0;
          busy     <= 1'b0;
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TPT_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `TPT_ASSERT_IMP(a_found_user, done && (out_user != '0), found, "user without found")
  `TPT_ASSERT_IMP(a_quiet_out, !done, !found && (out_user == '0), "result outside strobe")
  `TPT_ASSERT_IMP(a_chain_scan, chain[CELLS].active, state == S_SCAN, "token outside scan")
  `TPT_ASSERT_NXT(a_done_single, done, !done, "strobe on consecutive cycles")

endmodule

### hdl/tpt_cell.sv
module tpt_cell #(
  parameter int ROWS     = 256,
  parameter int ROW_W    = 8,
  parameter int CELL_IDX = 0
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  tpt_pkg::cell_cmd_t                       cmd,
  input  logic [ROW_W-1:0]                         wr_row,
  input  logic [ROW_W-1:0]                         rd_row,
  input  tpt_pkg::scan_t                           scan_in,
  input  logic [ROW_W-1:0]                         scan_row_in,
  input  logic [ROW_W+tpt_pkg::CELL_BITS-1:0]      scan_slot_in,
  output tpt_pkg::scan_t                           scan_out,
  output logic [ROW_W-1:0]                         scan_row_out,
  output logic [ROW_W+tpt_pkg::CELL_BITS-1:0]      scan_slot_out,
  output tpt_pkg::entry_t                          rd_word
);
  import tpt_pkg::*;

  localparam int SLOT_W = ROW_W + CELL_BITS;

  entry_t             mem [ROWS];
  logic [ROW_W-1:0]   raddr;
  scan_t              tok;
  logic [ROW_W-1:0]   tok_row;
  logic [SLOT_W-1:0]  tok_slot;
  logic               take;

  // scan token owns the read port while it passes
  assign raddr = scan_in.active ? scan_row_in : rd_row;

  always_ff @(posedge clk) begin
    rd_word <= mem[raddr];
    if (cmd.wr_en && (cmd.wr_all || (cmd.wr_cell == CELL_BITS'(CELL_IDX)))) begin
      mem[wr_row] <= cmd.wr_word;
    end
  end

  // local slot has the highest id of this row so far, so ties go to it
  assign take = rd_word.valid && (!tok.best_valid || (rd_word.prio >= tok.best_prio));

  always_ff @(posedge clk) begin
    tok      <= scan_in;
    tok_row  <= scan_row_in;
    tok_slot <= scan_slot_in;
    scan_out.active <= tok.active;
    scan_row_out    <= tok_row;
    if (take) begin
      scan_out.best_valid <= 1'b1;
      scan_out.best_prio  <= rd_word.prio;
      scan_out.best_user  <= rd_word.user;
      scan_slot_out       <= {tok_row, CELL_BITS'(CELL_IDX)};
    end else begin
      scan_out.best_valid <= tok.best_valid;
      scan_out.best_prio  <= tok.best_prio;
      scan_out.best_user  <= tok.best_user;
      scan_slot_out       <= tok_slot;
    end
    if (rst) begin
      tok.active      <= 1'b0;
      scan_out.active <= 1'b0;
    end
  end

endmodule
